@@ rtl/rbt_pkg.sv @@
// Shared types, constants and the microcode program of the retry backoff timer.
package rbt_pkg;

  localparam int REQ_W     = 2;
  localparam int TIME_W    = 32;
  localparam int BASE_W    = 16;
  localparam int MAXD_W    = 21;
  localparam int EXP_W     = 3;
  localparam int TALLY_W   = 4;
  localparam int SHIFT_W   = 23;
  localparam int CHOSEN_W  = 22;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 21;

  // Divide by five as a multiply by a scaled reciprocal; exact for any 22-bit operand.
  localparam int                RECIP_SH = 24;
  localparam int                RECIP_W  = 22;
  localparam logic [RECIP_W-1:0] RECIP5  = 22'd3355444;
  localparam int                PROD_W   = MAXD_W + RECIP_W;
  localparam int                QUO_W    = PROD_W - RECIP_SH;
  localparam int                DIV_W    = QUO_W + 1;
  localparam int                CNT_W    = 5;
  localparam logic [CNT_W-1:0]  MOD_LAST = 5'd31;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NOW   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_AFTER = 2'd2;
  localparam logic [REQ_W-1:0] REQ_FAIL  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP  = 2'd2;

  // Program steps.
  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;
  localparam pc_t S_IDLE   = 4'd0;
  localparam pc_t S_NOW    = 4'd1;
  localparam pc_t S_AFTER  = 4'd2;
  localparam pc_t S_SHIFT  = 4'd3;
  localparam pc_t S_CAP    = 4'd4;
  localparam pc_t S_MUL    = 4'd5;
  localparam pc_t S_DIVSET = 4'd6;
  localparam pc_t S_MOD    = 4'd7;
  localparam pc_t S_ADDJ   = 4'd8;
  localparam pc_t S_FUPD   = 4'd9;
  localparam pc_t S_RESP   = 4'd10;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR_TGT,
    OP_SCHED,
    OP_SHIFT,
    OP_CAP,
    OP_MUL,
    OP_DIVSET,
    OP_MODSTEP,
    OP_ADDJ,
    OP_FAIL_UPD,
    OP_RESP
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_CNT_NZ,
    COND_WAIT_IN,
    COND_WAIT_OUT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Sequencer to datapath.
  typedef struct packed {
    op_t  op;
    logic capture;
  } ctl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic cnt_nz;
    logic out_busy;
  } stat_t;

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '{op: OP_NONE, cond: COND_WAIT_IN, target: S_IDLE};
    unique case (pc)
      S_IDLE:   w = '{op: OP_NONE,     cond: COND_WAIT_IN,  target: S_IDLE};
      S_NOW:    w = '{op: OP_CLR_TGT,  cond: COND_JUMP,     target: S_RESP};
      S_AFTER:  w = '{op: OP_SCHED,    cond: COND_JUMP,     target: S_RESP};
      S_SHIFT:  w = '{op: OP_SHIFT,    cond: COND_NEXT,     target: S_IDLE};
      S_CAP:    w = '{op: OP_CAP,      cond: COND_NEXT,     target: S_IDLE};
      S_MUL:    w = '{op: OP_MUL,      cond: COND_NEXT,     target: S_IDLE};
      S_DIVSET: w = '{op: OP_DIVSET,   cond: COND_NEXT,     target: S_IDLE};
      S_MOD:    w = '{op: OP_MODSTEP,  cond: COND_CNT_NZ,   target: S_MOD};
      S_ADDJ:   w = '{op: OP_ADDJ,     cond: COND_NEXT,     target: S_IDLE};
      S_FUPD:   w = '{op: OP_FAIL_UPD, cond: COND_JUMP,     target: S_RESP};
      S_RESP:   w = '{op: OP_RESP,     cond: COND_WAIT_OUT, target: S_IDLE};
      default:  w = '{op: OP_NONE,     cond: COND_JUMP,     target: S_IDLE};
    endcase
    return w;
  endfunction

  function automatic pc_t dispatch(input logic [REQ_W-1:0] req);
    pc_t p;
    p = S_RESP;
    unique case (req)
      REQ_QUERY: p = S_RESP;
      REQ_NOW:   p = S_NOW;
      REQ_AFTER: p = S_AFTER;
      REQ_FAIL:  p = S_SHIFT;
      default:   p = S_RESP;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/rbt_ifs.sv @@
// Handshake interfaces for the request, response and configuration channels.
interface rbt_req_if;
  logic                           valid;
  logic                           ready;
  logic [rbt_pkg::REQ_W-1:0]      req_type;
  logic [rbt_pkg::TIME_W-1:0]     now_ms;
  logic [rbt_pkg::TIME_W-1:0]     delay_ms;
  logic [rbt_pkg::TIME_W-1:0]     random_word;
  modport source (output valid, req_type, now_ms, delay_ms, random_word, input ready);
  modport sink (input valid, req_type, now_ms, delay_ms, random_word, output ready);
endinterface

interface rbt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           is_due;
  logic [rbt_pkg::CHOSEN_W-1:0]   delay_chosen;
  logic [rbt_pkg::TALLY_W-1:0]    failure_count;
  modport source (output valid, is_due, delay_chosen, failure_count, input ready);
  modport sink (input valid, is_due, delay_chosen, failure_count, output ready);
endinterface

interface rbt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rbt_pkg::CFG_IDX_W-1:0]   index;
  logic [rbt_pkg::CFG_DAT_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/rbt_seq.sv @@
// Microcode sequencer: step counter, control store and jump logic.
module rbt_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [rbt_pkg::REQ_W-1:0] in_req_type,
  output logic                      in_ready,
  input  rbt_pkg::stat_t            stat,
  output rbt_pkg::ctl_t             ctl
);

  rbt_pkg::pc_t    pc;
  rbt_pkg::pc_t    pc_next;
  rbt_pkg::uword_t uw;
  logic            fire;

  assign uw       = rbt_pkg::ucode(pc);
  assign in_ready = !rst && (uw.cond == rbt_pkg::COND_WAIT_IN);
  assign fire     = in_valid & in_ready;
  assign ctl.op      = uw.op;
  assign ctl.capture = fire;

  always_comb begin
    pc_next = pc;
    unique case (uw.cond)
      rbt_pkg::COND_NEXT:     pc_next = pc + rbt_pkg::pc_t'(1);
      rbt_pkg::COND_JUMP:     pc_next = uw.target;
      rbt_pkg::COND_CNT_NZ:   pc_next = stat.cnt_nz ? uw.target : pc + rbt_pkg::pc_t'(1);
      rbt_pkg::COND_WAIT_IN:  pc_next = fire ? rbt_pkg::dispatch(in_req_type) : pc;
      rbt_pkg::COND_WAIT_OUT: pc_next = stat.out_busy ? pc : uw.target;
      default:                pc_next = rbt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= rbt_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

`ifndef SYNTHESIS
  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    pc <= rbt_pkg::S_RESP)
    else $error("step counter left the program");
`endif

endmodule

@@ rtl/rbt_dpath.sv @@
// Datapath: configuration, timer state, backoff arithmetic, serial modulo and result register.
module rbt_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  rbt_pkg::ctl_t                 ctl,
  output rbt_pkg::stat_t                stat,
  input  logic                          cfg_we,
  input  logic [rbt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbt_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic [rbt_pkg::TIME_W-1:0]    in_now_ms,
  input  logic [rbt_pkg::TIME_W-1:0]    in_delay_ms,
  input  logic [rbt_pkg::TIME_W-1:0]    in_random_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_is_due,
  output logic [rbt_pkg::CHOSEN_W-1:0]  out_delay_chosen,
  output logic [rbt_pkg::TALLY_W-1:0]   out_failure_count
);

  logic [rbt_pkg::BASE_W-1:0]   base_delay_ms;
  logic [rbt_pkg::MAXD_W-1:0]   max_delay_ms;
  logic [rbt_pkg::EXP_W-1:0]    max_exponent;
  logic [rbt_pkg::TALLY_W-1:0]  failure_tally;
  logic [rbt_pkg::TIME_W-1:0]   next_attempt_time;

  logic [rbt_pkg::TIME_W-1:0]   now_q;
  logic [rbt_pkg::TIME_W-1:0]   dly_q;
  logic [rbt_pkg::TIME_W-1:0]   rnd_sh;
  logic [rbt_pkg::SHIFT_W-1:0]  acc;
  logic [rbt_pkg::PROD_W-1:0]   prod;
  logic [rbt_pkg::DIV_W-1:0]    div;
  logic [rbt_pkg::DIV_W-1:0]    rem;
  logic [rbt_pkg::CNT_W-1:0]    cnt;
  logic [rbt_pkg::CHOSEN_W-1:0] chosen;

  logic [rbt_pkg::EXP_W-1:0]    exp_eff;
  logic [rbt_pkg::DIV_W:0]      rem_sh;
  logic [rbt_pkg::DIV_W-1:0]    rem_next;
  logic [rbt_pkg::CHOSEN_W-1:0] total;
  logic [rbt_pkg::TALLY_W-1:0]  tally_cap;
  logic [rbt_pkg::TIME_W-1:0]   since_tgt;
  logic                         due;
  logic                         load_out;

  assign exp_eff   = (failure_tally > {1'b0, max_exponent}) ? max_exponent
                                                            : failure_tally[rbt_pkg::EXP_W-1:0];
  assign tally_cap = {1'b0, max_exponent} + rbt_pkg::TALLY_W'(1);

  // One restoring step of random_word modulo div, most significant bit first.
  always_comb begin
    rem_sh = {rem, rnd_sh[rbt_pkg::TIME_W-1]};
    if (rem_sh >= {1'b0, div}) begin
      rem_next = rbt_pkg::DIV_W'(rem_sh - {1'b0, div});
    end else begin
      rem_next = rem_sh[rbt_pkg::DIV_W-1:0];
    end
  end

  assign total     = rbt_pkg::CHOSEN_W'(acc[rbt_pkg::MAXD_W-1:0]) + rbt_pkg::CHOSEN_W'(rem);
  assign since_tgt = now_q - next_attempt_time;
  assign due       = (next_attempt_time == '0) || !since_tgt[rbt_pkg::TIME_W-1];

  assign stat.out_busy = out_valid & ~out_ready;
  assign stat.cnt_nz   = (cnt != '0);
  assign load_out      = (ctl.op == rbt_pkg::OP_RESP) && !stat.out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay_ms     <= 16'd1000;
      max_delay_ms      <= 21'd60000;
      max_exponent      <= 3'd5;
      failure_tally     <= '0;
      next_attempt_time <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rbt_pkg::CFG_BASE: base_delay_ms <= cfg_data[rbt_pkg::BASE_W-1:0];
          rbt_pkg::CFG_MAXD: max_delay_ms  <= cfg_data[rbt_pkg::MAXD_W-1:0];
          rbt_pkg::CFG_EXP:  max_exponent  <= cfg_data[rbt_pkg::EXP_W-1:0];
          default: ;
        endcase
      end
      unique case (ctl.op)
        rbt_pkg::OP_CLR_TGT: next_attempt_time <= '0;
        rbt_pkg::OP_SCHED: begin
          failure_tally     <= '0;
          next_attempt_time <= now_q + dly_q;
        end
        rbt_pkg::OP_FAIL_UPD: begin
          if (failure_tally < tally_cap) begin
            failure_tally <= failure_tally + rbt_pkg::TALLY_W'(1);
          end
          next_attempt_time <= now_q + rbt_pkg::TIME_W'(chosen);
        end
        default: ;
      endcase
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers carry no reset.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      now_q  <= in_now_ms;
      dly_q  <= in_delay_ms;
      rnd_sh <= in_random_word;
      chosen <= '0;
    end
    unique case (ctl.op)
      rbt_pkg::OP_SHIFT: acc <= rbt_pkg::SHIFT_W'(base_delay_ms) << exp_eff;
      rbt_pkg::OP_CAP: begin
        if (acc > rbt_pkg::SHIFT_W'(max_delay_ms)) begin
          acc <= rbt_pkg::SHIFT_W'(max_delay_ms);
        end
      end
      rbt_pkg::OP_MUL: begin
        prod <= rbt_pkg::PROD_W'(acc[rbt_pkg::MAXD_W-1:0]) * rbt_pkg::PROD_W'(rbt_pkg::RECIP5);
      end
      rbt_pkg::OP_DIVSET: begin
        div <= {1'b0, prod[rbt_pkg::PROD_W-1:rbt_pkg::RECIP_SH]} + rbt_pkg::DIV_W'(1);
        rem <= '0;
        cnt <= rbt_pkg::MOD_LAST;
      end
      rbt_pkg::OP_MODSTEP: begin
        rem    <= rem_next;
        rnd_sh <= {rnd_sh[rbt_pkg::TIME_W-2:0], 1'b0};
        cnt    <= cnt - rbt_pkg::CNT_W'(1);
      end
      rbt_pkg::OP_ADDJ: chosen <= total;
      default: ;
    endcase
    if (load_out) begin
      out_is_due        <= due;
      out_delay_chosen  <= chosen;
      out_failure_count <= failure_tally;
    end
  end

`ifndef SYNTHESIS
  a_tally_bound: assert property (@(posedge clk) disable iff (rst)
    failure_tally <= 4'd8)
    else $error("failure tally above its saturation point");
`endif

`ifndef SYNTHESIS
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == rbt_pkg::OP_MODSTEP) |=> (rem < div))
    else $error("jitter remainder not reduced below the divisor");
`endif

`ifndef SYNTHESIS
  a_load_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.op == rbt_pkg::OP_RESP))
    else $error("result presented outside the response step");
`endif

endmodule

@@ rtl/retry_backoff_timer.sv @@
// Retry backoff timer: a microcoded sequencer driving the backoff datapath.
// Requests are taken one at a time. Once a request is accepted, a due query goes to the
// response step, schedule-now and schedule-after pass through the step that clears or
// sets the target, and a failure request runs shift, cap, multiply, divisor set-up, the
// modulo loop, jitter add and failure update. A serial restoring unit works out the
// jitter remainder one bit of the 32-bit random word per cycle. The next request can be
// accepted in the cycle after the result register is loaded, and a result that is not
// taken holds the sequencer in its response step. Configuration writes are accepted in
// every cycle outside reset and should be made only while no request is in flight.
module retry_backoff_timer (
  input logic      clk,
  input logic      rst,
  rbt_cfg_if.sink  cfg,
  rbt_req_if.sink  req,
  rbt_rsp_if.source rsp
);

  rbt_pkg::ctl_t  ctl;
  rbt_pkg::stat_t stat;
  logic           in_ready;

  assign cfg.ready = ~rst;
  assign req.ready = in_ready;

  rbt_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_req_type (req.req_type),
    .in_ready    (in_ready),
    .stat        (stat),
    .ctl         (ctl)
  );

  rbt_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .stat              (stat),
    .cfg_we            (cfg.valid & cfg.ready),
    .cfg_index         (cfg.index),
    .cfg_data          (cfg.data),
    .in_now_ms         (req.now_ms),
    .in_delay_ms       (req.delay_ms),
    .in_random_word    (req.random_word),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .out_is_due        (rsp.is_due),
    .out_delay_chosen  (rsp.delay_chosen),
    .out_failure_count (rsp.failure_count)
  );

endmodule
